@@ design/urfr_pkg.sv @@
// ----------------------------------------------------------------------------
// urfr_pkg: ultrasonic ranging frame receiver package
// Shared widths, codes and defaults for the receiver and its channels.
// ----------------------------------------------------------------------------
package urfr_pkg;

    // Field widths
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned DIST_W     = 13;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned TIMEOUT_W  = 16;

    // Tick threshold is the reply timeout / 10, at most 6553: 13 bits
    localparam int unsigned LIMIT_W    = 13;

    // Defaults
    localparam int unsigned DEFAULT_MAX_DISTANCE = 4500;
    localparam logic [TIMEOUT_W-1:0] DEFAULT_TIMEOUT_MS = 16'd2000;

    // Reciprocal of ten: (x * 52429) >> 19 equals x / 10 for any 16-bit x
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int unsigned RECIP_SHIFT = 19;

    // Item kinds
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_PENDING = 3'd1,
        ST_TIMEOUT = 3'd2,
        ST_CHECK   = 3'd3,
        ST_STORED  = 3'd4
    } status_t;

endpackage

@@ design/urfr_if.sv @@
// ----------------------------------------------------------------------------
// urfr_if: receiver channel interfaces
// Valid/ready channels for incoming items and for result items.
// ----------------------------------------------------------------------------

// Incoming item: tick or received byte
interface urfr_req_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [urfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// Result item: one per incoming item
interface urfr_res_if;
    logic                         valid;
    logic                         ready;
    urfr_pkg::status_t            status;
    logic                         send_trigger;
    logic [urfr_pkg::DIST_W-1:0]  distance;
    logic                         distance_valid;
    logic [urfr_pkg::COUNT_W-1:0] checksum_errors;

    modport source (output valid, output status, output send_trigger, output distance,
                    output distance_valid, output checksum_errors, input ready);
    modport sink   (input valid, input status, input send_trigger, input distance,
                    input distance_valid, input checksum_errors, output ready);
endinterface

@@ design/ultrasonic_ranging_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_ranging_frame_receiver_unit: UART range sensor poll logic
// Trigger on tick, reply timeout, three-byte frame capture and checksum.
// ----------------------------------------------------------------------------
// Each accepted item's result is captured in the output register as it is accepted.
// Throughput: one item per cycle while results are taken; the state update
// and result capture share one clock edge, and the output register accepts a
// new item while its held result is taken in the same cycle.
// Reset (rst_n, asynchronous, active low): frame idle, counters, distance and
// valid cleared, tick threshold set from a 2000 ms timeout; output empty.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_frame_receiver_unit #(
    parameter int unsigned MAX_DISTANCE = urfr_pkg::DEFAULT_MAX_DISTANCE
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [urfr_pkg::TIMEOUT_W-1:0] cfg_wdata,
    urfr_req_if.sink                       request,
    urfr_res_if.source                     result
);
    import urfr_pkg::*;

    localparam logic [15:0] MAX_DIST_LIM = 16'(MAX_DISTANCE);
    localparam logic [LIMIT_W-1:0] RESET_LIMIT =
        LIMIT_W'(DEFAULT_TIMEOUT_MS / 10);

    // Frame position, one-hot
    typedef enum logic [3:0] {
        FP_IDLE  = 4'b0001,
        FP_HIGH  = 4'b0010,
        FP_LOW   = 4'b0100,
        FP_CHECK = 4'b1000
    } frame_t;

    frame_t               frame_reg, frame_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [LIMIT_W-1:0]   wait_reg, wait_next;
    logic [BYTE_W-1:0]    high_reg, high_next;
    logic [BYTE_W-1:0]    low_reg, low_next;
    logic [DIST_W-1:0]    dist_reg, dist_next;
    logic                 rvalid_reg, rvalid_next;
    logic [COUNT_W-1:0]   errs_reg, errs_next;

    status_t              status_next;
    logic                 trigger_next;

    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic                 out_trigger_reg;
    logic [DIST_W-1:0]    out_dist_reg;
    logic                 out_dvalid_reg;
    logic [COUNT_W-1:0]   out_errs_reg;

    logic                 accept;
    logic [31:0]          recip_prod;
    logic [LIMIT_W-1:0]   wait_inc;
    logic [BYTE_W-1:0]    sum8;
    logic [15:0]          frame_value;

    // Handshake: output register frees when empty or being taken
    assign request.ready = !out_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;

    // Tick threshold from the written timeout, by reciprocal multiply
    assign recip_prod = 32'(cfg_wdata) * 32'(RECIP_TEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= RESET_LIMIT;
        end
        else if (cfg_we)
        begin
            limit_reg <= recip_prod[RECIP_SHIFT +: LIMIT_W];
        end
    end

    // Per-item state update and result
    assign wait_inc    = wait_reg + 1'b1;
    assign sum8        = high_reg + low_reg;
    assign frame_value = {high_reg, low_reg};

    always_comb
    begin
        frame_next   = frame_reg;
        wait_next    = wait_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        dist_next    = dist_reg;
        rvalid_next  = rvalid_reg;
        errs_next    = errs_reg;
        status_next  = ST_OK;
        trigger_next = 1'b0;

        if (request.cmd == CMD_TICK)
        begin
            if (frame_reg == FP_IDLE)
            begin
                // start a measurement
                wait_next    = '0;
                frame_next   = FP_HIGH;
                trigger_next = 1'b1;
                status_next  = ST_OK;
            end
            else if (wait_inc >= limit_reg)
            begin
                frame_next  = FP_IDLE;
                wait_next   = '0;
                rvalid_next = 1'b0;
                status_next = ST_TIMEOUT;
            end
            else
            begin
                wait_next   = wait_inc;
                status_next = ST_PENDING;
            end
        end
        else
        begin
            unique case (frame_reg)
                FP_IDLE:
                begin
                    // byte while idle is dropped but still advances
                    frame_next  = FP_HIGH;
                    status_next = ST_STORED;
                end
                FP_HIGH:
                begin
                    high_next   = request.rx_byte;
                    frame_next  = FP_LOW;
                    status_next = ST_STORED;
                end
                FP_LOW:
                begin
                    low_next    = request.rx_byte;
                    frame_next  = FP_CHECK;
                    status_next = ST_STORED;
                end
                FP_CHECK:
                begin
                    frame_next = FP_IDLE;
                    if (sum8 != request.rx_byte)
                    begin
                        errs_next   = errs_reg + 1'b1;
                        rvalid_next = 1'b0;
                        status_next = ST_CHECK;
                    end
                    else
                    begin
                        if (frame_value <= MAX_DIST_LIM)
                        begin
                            dist_next   = frame_value[DIST_W-1:0];
                            rvalid_next = 1'b1;
                        end
                        else
                        begin
                            rvalid_next = 1'b0;
                        end
                        status_next = ST_OK;
                    end
                end
                default:
                begin
                    frame_next  = FP_IDLE;
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg  <= FP_IDLE;
            wait_reg   <= '0;
            high_reg   <= '0;
            low_reg    <= '0;
            dist_reg   <= '0;
            rvalid_reg <= 1'b0;
            errs_reg   <= '0;
        end
        else if (accept)
        begin
            frame_reg  <= frame_next;
            wait_reg   <= wait_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
            dist_reg   <= dist_next;
            rvalid_reg <= rvalid_next;
            errs_reg   <= errs_next;
        end
    end

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg  <= status_next;
            out_trigger_reg <= trigger_next;
            out_dist_reg    <= dist_next;
            out_dvalid_reg  <= rvalid_next;
            out_errs_reg    <= errs_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.status          = out_status_reg;
    assign result.send_trigger    = out_trigger_reg;
    assign result.distance        = out_dist_reg;
    assign result.distance_valid  = out_dvalid_reg;
    assign result.checksum_errors = out_errs_reg;

    // Assertions

    // a tick while idle always asks for a trigger
    a_tick_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.cmd == CMD_TICK && frame_reg == FP_IDLE)
        |=> (result.valid && result.send_trigger && result.status == ST_OK))
        else $error("idle tick did not raise send_trigger");

    // error count moves only with an accepted item
    a_errs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(errs_reg))
        else $error("checksum error count changed without an item");

    // a valid reading never exceeds the range limit
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.distance_valid)
        |-> (16'(result.distance) <= MAX_DIST_LIM))
        else $error("valid distance above range limit");

    // a checksum failure result always clears the reading valid flag
    a_check_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_CHECK) |-> !result.distance_valid)
        else $error("checksum failure left distance valid");

endmodule

@@ test/tb_ultrasonic_ranging_frame_receiver_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_ranging_frame_receiver_unit: range sensor poll testbench
// Drives ticks and sensor reply bytes through the request channel, predicts
// every result item from a software copy of the poll state and compares each
// accepted result with the oldest prediction. Covers several reply timeouts,
// good, bad and out-of-range frames, stray bytes and a long output stall.
// ----------------------------------------------------------------------------
module tb_ultrasonic_ranging_frame_receiver_unit;
    import urfr_pkg::*;

    localparam int unsigned CLK_HALF     = 5;
    localparam int unsigned RESET_CYCLES = 10;
    localparam int unsigned RANDOM_ITEMS = 1750;
    localparam int unsigned PHASE_COUNT  = 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 5;
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    // Reply timeouts per random phase; the last one is replaced by a random value
    localparam logic [TIMEOUT_W-1:0] PHASE_TIMEOUTS [PHASE_COUNT] =
        '{16'd0, 16'd30, 16'd9, 16'd10, 16'd150, 16'd65535, 16'd2000, 16'd100};

    // One result item as seen on the output channel
    typedef struct {
        status_t            status;
        logic               send_trigger;
        logic [DIST_W-1:0]  distance;
        logic               distance_valid;
        logic [COUNT_W-1:0] checksum_errors;
    } reading_t;

    // ------------------------------------------------------------------------
    // Poll state tracker and store of expected readings
    // ------------------------------------------------------------------------
    class ranging_scoreboard;
        logic [TIMEOUT_W-1:0] reply_timeout;
        logic [1:0]           frame_pos;
        logic [15:0]          wait_ticks;
        logic [BYTE_W-1:0]    high_byte;
        logic [BYTE_W-1:0]    low_byte;
        logic [DIST_W-1:0]    last_distance;
        logic                 reading_valid;
        logic [COUNT_W-1:0]   error_count;
        reading_t             expected_readings [$];
        int unsigned          failures;

        function new();
            reply_timeout = DEFAULT_TIMEOUT_MS;
            frame_pos     = 2'd0;
            wait_ticks    = 16'd0;
            high_byte     = '0;
            low_byte      = '0;
            last_distance = '0;
            reading_valid = 1'b0;
            error_count   = '0;
            failures      = 0;
        endfunction

        function void set_timeout(logic [TIMEOUT_W-1:0] value);
            reply_timeout = value;
        endfunction

        function int unsigned outstanding();
            return expected_readings.size();
        endfunction

        // Advance the poll state by one item and return the reading it gives
        function reading_t predict_reading(logic kind, logic [BYTE_W-1:0] value);
            reading_t          r;
            logic [15:0]       limit;
            logic [15:0]       frame_value;
            logic [BYTE_W-1:0] sum;
            r.send_trigger = 1'b0;
            if (kind == CMD_TICK)
            begin
                if (frame_pos == 2'd0)
                begin
                    // idle: ask for a measurement
                    wait_ticks     = 16'd0;
                    frame_pos      = 2'd1;
                    r.send_trigger = 1'b1;
                    r.status       = ST_OK;
                end
                else
                begin
                    wait_ticks = wait_ticks + 16'd1;
                    limit      = reply_timeout / 16'd10;
                    if (wait_ticks >= limit)
                    begin
                        frame_pos     = 2'd0;
                        wait_ticks    = 16'd0;
                        reading_valid = 1'b0;
                        r.status      = ST_TIMEOUT;
                    end
                    else
                        r.status = ST_PENDING;
                end
            end
            else if (frame_pos == 2'd3)
            begin
                // checksum byte closes the frame
                sum       = high_byte + low_byte;
                frame_pos = 2'd0;
                if (sum != value)
                begin
                    error_count   = error_count + 1'b1;
                    reading_valid = 1'b0;
                    r.status      = ST_CHECK;
                end
                else
                begin
                    frame_value = {high_byte, low_byte};
                    if (frame_value <= DEFAULT_MAX_DISTANCE)
                    begin
                        last_distance = frame_value[DIST_W-1:0];
                        reading_valid = 1'b1;
                    end
                    else
                        reading_valid = 1'b0;
                    r.status = ST_OK;
                end
            end
            else
            begin
                // a high or low byte is stored; a stray byte while idle only moves the frame index on
                if (frame_pos == 2'd1)
                    high_byte = value;
                else if (frame_pos == 2'd2)
                    low_byte = value;
                frame_pos = frame_pos + 2'd1;
                r.status  = ST_STORED;
            end
            r.distance        = last_distance;
            r.distance_valid  = reading_valid;
            r.checksum_errors = error_count;
            return r;
        endfunction

        function void note_item(logic kind, logic [BYTE_W-1:0] value);
            expected_readings.push_back(predict_reading(kind, value));
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t: result item with nothing expected, status %0d",
                             $realtime, got.status);
                return;
            end
            want = expected_readings.pop_front();
            if (got.status !== want.status || got.send_trigger !== want.send_trigger ||
                got.distance !== want.distance || got.distance_valid !== want.distance_valid ||
                got.checksum_errors !== want.checksum_errors)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                begin
                    $display("%0t: mismatch, expected status %0d trig %0b dist %0d valid %0b errs %0d",
                             $realtime, want.status, want.send_trigger, want.distance,
                             want.distance_valid, want.checksum_errors);
                    $display("%0t:           got status %0d trig %0b dist %0d valid %0b errs %0d",
                             $realtime, got.status, got.send_trigger, got.distance,
                             got.distance_valid, got.checksum_errors);
                end
            end
        endfunction

        function void report_leftover();
            if (expected_readings.size() != 0)
            begin
                failures++;
                $display("%0d result items never arrived", expected_readings.size());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and block
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [TIMEOUT_W-1:0] cfg_wdata;
    logic                 hold_request;
    int unsigned          burst_left;
    int unsigned          items_sent;
    ranging_scoreboard    board;

    urfr_req_if items_in ();
    urfr_res_if readings_out ();

    ultrasonic_ranging_frame_receiver_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (items_in),
        .result    (readings_out)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender: bursts of items with random gaps between them
    // ------------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [BYTE_W-1:0] value);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                items_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        items_in.valid   <= 1'b1;
        items_in.cmd     <= kind;
        items_in.rx_byte <= value;
        do
            @(posedge clk);
        while (!items_in.ready);
        board.note_item(kind, value);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, BYTE_W'($urandom));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        send_item(CMD_BYTE, value);
    endtask

    // Poll followed by a full reply frame
    task automatic send_frame(input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo,
                              input logic [BYTE_W-1:0] sum);
        send_tick();
        send_byte(hi);
        send_byte(lo);
        send_byte(sum);
    endtask

    // Timeout register write once every result item is back
    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        items_in.valid <= 1'b0;
        burst_left = 0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_timeout(value);
    endtask

    // Mostly well-formed poll/reply exchanges, plus tick runs and stray bytes
    task automatic run_random_phase(input int unsigned quota);
        int unsigned       first_item;
        int unsigned       pick;
        int unsigned       n;
        logic [15:0]       reply;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] sum;
        first_item = items_sent;
        while (items_sent - first_item < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                send_tick();
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                repeat (n) send_tick();
                case ($urandom_range(0, 3))
                    0:       reply = 16'($urandom_range(0, DEFAULT_MAX_DISTANCE));
                    1:       reply = 16'($urandom_range(DEFAULT_MAX_DISTANCE - 5,
                                                        DEFAULT_MAX_DISTANCE + 5));
                    default: reply = 16'($urandom);
                endcase
                hi  = reply[15:8];
                lo  = reply[7:0];
                sum = hi + lo;
                if ($urandom_range(0, 6) == 0)
                    sum = sum + BYTE_W'($urandom_range(1, 255));
                send_byte(hi);
                if ($urandom_range(0, 9) == 0)
                    send_tick();
                send_byte(lo);
                if ($urandom_range(0, 9) == 0)
                    send_tick();
                send_byte(sum);
            end
            else if (pick < 85)
            begin
                n = $urandom_range(1, 16);
                repeat (n) send_tick();
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(BYTE_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall pattern, long hold on request, result checking
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned       mode;
        int unsigned       mode_left;
        int unsigned       hold_left;
        int unsigned       cycle_count;
        logic [7:0]        stall_mask;
        logic              next_ready;
        reading_t          got;
        readings_out.ready = 1'b0;
        mode_left   = 0;
        hold_left   = 0;
        cycle_count = 0;
        mode        = 0;
        stall_mask  = 8'hff;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (readings_out.valid && readings_out.ready)
            begin
                got.status          = readings_out.status;
                got.send_trigger    = readings_out.send_trigger;
                got.distance        = readings_out.distance;
                got.distance_valid  = readings_out.distance_valid;
                got.checksum_errors = readings_out.checksum_errors;
                board.check_reading(got);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            // pick a new stall mode now and then
            if (mode_left == 0)
            begin
                mode       = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 128);
                stall_mask = 8'($urandom);
            end
            mode_left--;
            cycle_count++;
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
                case (mode)
                    0:       next_ready = 1'b1;
                    1:       next_ready = stall_mask[3'(cycle_count)];
                    2:       next_ready = ($urandom_range(0, 3) != 0);
                    default: next_ready = ($urandom_range(0, 3) == 0);
                endcase
            readings_out.ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [TIMEOUT_W-1:0] timeout_value;
        board            = new();
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        hold_request     = 1'b0;
        burst_left       = 0;
        items_sent       = 0;
        items_in.valid   = 1'b0;
        items_in.cmd     = CMD_TICK;
        items_in.rx_byte = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: stray byte, pending tick, frame extremes, range edge, bad sum
        send_byte(8'h5a);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h00);
        send_tick();
        send_tick();
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_frame(8'h11, 8'h94, 8'ha5);
        send_frame(8'h11, 8'h95, 8'ha6);
        send_frame(8'hff, 8'hff, 8'hfe);
        send_frame(8'h12, 8'h34, 8'h00);

        // Threshold below one tick: first wait tick times out
        write_timeout(16'd5);
        send_tick();
        send_tick();

        // Random phases over a range of reply timeouts
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            timeout_value = (p == PHASE_COUNT - 1) ? TIMEOUT_W'($urandom_range(10, 400))
                                                   : PHASE_TIMEOUTS[p];
            write_timeout(timeout_value);
            if (p == 2 || p == 5)
                hold_request = 1'b1;
            run_random_phase(RANDOM_ITEMS / PHASE_COUNT);
        end

        // Drain and report
        items_in.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        board.report_leftover();
        if (board.failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit
    initial
    begin
        #RUN_LIMIT_NS;
        $display("Run limit reached");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
